>>> rtl/core/diff_drive_odometry_macros.svh
// Assertion macros shared by the odometry checker.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define DDO_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");

// The consequent must hold in the same clock as the antecedent.
`define DDO_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");

`endif

>>> rtl/core/ddo_pkg.sv
// Shared types, constants and tables of the differential drive odometry block.
package ddo_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_TICK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TICK = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK  = 8'd2;

    // Register reset values.
    localparam logic [31:0] LEFT_TICK_RST  = 32'd75320;
    localparam logic [31:0] RIGHT_TICK_RST = 32'd60446;
    localparam logic [31:0] INV_TRACK_RST  = 32'd697515587;

    // Rotation datapath width and start vector (Q4.30, includes the gain).
    localparam int ROT_W = 34;
    localparam logic signed [ROT_W-1:0] ROT_X0 = 34'sd652032874;

    // Divider widths: magnitude of a scaled numerator and the denominator.
    localparam int NUM_W = 54;
    localparam int DEN_W = 33;

    // Scale from microseconds to seconds.
    localparam logic signed [ROT_W-1:0] US_PER_S = 34'sd1000000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_SUM,
        ST_MUL_H,
        ST_HEAD,
        ST_ROT,
        ST_ROT_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_POS_Y,
        ST_MUL_F,
        ST_DIV_F,
        ST_MUL_W,
        ST_DIV_W,
        ST_OUT
    } ddo_state_t;

    // Rotation unit result.
    typedef struct packed {
        logic                    done;
        logic signed [ROT_W-1:0] cos_v;
        logic signed [ROT_W-1:0] sin_v;
    } ddo_trig_t;

    // Divider result.
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } ddo_quot_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/ddo_if.sv
// Channel interfaces of the odometry block: samples in, poses out, register writes.
interface ddo_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic        [23:0] elapsed_us;

    modport source (output valid, left_count, right_count, elapsed_us, input ready);
    modport sink   (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface ddo_pose_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] x_pos;
    logic signed [47:0] y_pos;
    logic        [15:0] heading_out;
    logic signed [31:0] forward_speed;
    logic signed [31:0] yaw_rate;
    logic               time_fault;

    modport source (output valid, x_pos, y_pos, heading_out, forward_speed, yaw_rate,
                    time_fault, input ready);
    modport sink   (input valid, x_pos, y_pos, heading_out, forward_speed, yaw_rate,
                    time_fault, output ready);
endinterface

interface ddo_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ddo_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/diff_drive_odometry.sv
// Top level of the differential drive odometry block.
// A sample beat is followed by its result beat once the sample has passed through the
// shared 34x34 multiplier, the rotation unit, and two passes of the 54-step bit-serial
// divider for forward speed and yaw rate. A sample with zero elapsed time skips the
// divider. The next sample is taken in the cycle after the result beat at the earliest.
// One sample is in flight at a time: sample.ready is high only while the block is idle,
// and the result is held until pose.ready takes it. Register writes are taken in any
// cycle and must only be issued while the block is idle.
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ddo_sample_if.sink   sample,
    ddo_pose_if.source   pose,
    ddo_cfg_if.sink      cfg
);
    localparam int PROD_W = 2 * ddo_pkg::ROT_W;

    ddo_pkg::ddo_state_t state_reg;
    ddo_pkg::ddo_state_t state_next;

    // Configuration and persistent pose state.
    logic [31:0]        left_tick_reg;
    logic [31:0]        right_tick_reg;
    logic [31:0]        inv_track_reg;
    logic [31:0]        last_left_reg;
    logic [31:0]        last_right_reg;
    logic [31:0]        heading_reg;
    logic [47:0]        x_reg;
    logic [47:0]        y_reg;

    // Per-sample working registers.
    logic [31:0]        left_cnt_reg;
    logic [31:0]        right_cnt_reg;
    logic [23:0]        elapsed_reg;
    logic signed [31:0] left_m_reg;
    logic signed [32:0] diff_reg;
    logic signed [32:0] sum_reg;
    logic [31:0]        h_reg;
    logic signed [31:0] fwd_reg;
    logic signed [31:0] yaw_reg;
    logic               fault_reg;
    logic               neg_reg;
    logic               start_pend_reg;

    // Shared multiplier.
    logic signed [ddo_pkg::ROT_W-1:0] mul_a;
    logic signed [ddo_pkg::ROT_W-1:0] mul_b;
    logic signed [PROD_W-1:0]         prod_reg;

    logic signed [31:0]               right_m;
    logic [55:0]                      h_round;
    logic [31:0]                      half_h;
    logic signed [31:0]               mean_s;
    logic signed [PROD_W-1:0]         pos_round;
    logic signed [47:0]               pos_step;
    logic [PROD_W-1:0]                prod_mag;
    logic [ddo_pkg::NUM_W-1:0]        div_num;
    logic [ddo_pkg::DEN_W-1:0]        div_den;

    logic                             rot_start;
    logic                             div_start;
    ddo_pkg::ddo_trig_t               trig;
    ddo_pkg::ddo_quot_t               quot;

    // Clamp a product to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > PROD_W'(64'sd2147483647))
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < -PROD_W'(64'sd2147483648))
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Signed, saturated quotient from a magnitude and the numerator sign.
    function automatic logic signed [31:0] sat_quot(input logic [ddo_pkg::NUM_W-1:0] q,
                                                    input logic neg);
        logic signed [31:0] r;
        if (!neg)
        begin
            r = (q > ddo_pkg::NUM_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : 32'(q);
        end
        else
        begin
            r = (q >= ddo_pkg::NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -32'(q);
        end
        return r;
    endfunction

    // Derived values read from the working registers.
    assign right_m   = sat32(prod_reg);
    assign h_round   = prod_reg[55:0] + 56'h80_0000;
    assign half_h    = {h_reg[31], h_reg[31:1]};
    assign mean_s    = 32'(sum_reg >>> 1);
    assign pos_round = prod_reg + PROD_W'(64'sh2000_0000);
    assign pos_step  = 48'(pos_round >>> 30);
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_num   = prod_mag[ddo_pkg::NUM_W-1:0];

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddo_pkg::ST_IDLE:     if (sample.valid) state_next = ddo_pkg::ST_MUL_L;
            ddo_pkg::ST_MUL_L:    state_next = ddo_pkg::ST_MUL_R;
            ddo_pkg::ST_MUL_R:    state_next = ddo_pkg::ST_SUM;
            ddo_pkg::ST_SUM:      state_next = ddo_pkg::ST_MUL_H;
            ddo_pkg::ST_MUL_H:    state_next = ddo_pkg::ST_HEAD;
            ddo_pkg::ST_HEAD:     state_next = ddo_pkg::ST_ROT;
            ddo_pkg::ST_ROT:      state_next = ddo_pkg::ST_ROT_WAIT;
            ddo_pkg::ST_ROT_WAIT: if (trig.done) state_next = ddo_pkg::ST_MUL_X;
            ddo_pkg::ST_MUL_X:    state_next = ddo_pkg::ST_MUL_Y;
            ddo_pkg::ST_MUL_Y:    state_next = ddo_pkg::ST_POS_Y;
            ddo_pkg::ST_POS_Y:
            begin
                state_next = (elapsed_reg == 24'd0) ? ddo_pkg::ST_OUT : ddo_pkg::ST_MUL_F;
            end
            ddo_pkg::ST_MUL_F:    state_next = ddo_pkg::ST_DIV_F;
            ddo_pkg::ST_DIV_F:    if (quot.done) state_next = ddo_pkg::ST_MUL_W;
            ddo_pkg::ST_MUL_W:    state_next = ddo_pkg::ST_DIV_W;
            ddo_pkg::ST_DIV_W:    if (quot.done) state_next = ddo_pkg::ST_OUT;
            ddo_pkg::ST_OUT:      if (pose.ready) state_next = ddo_pkg::ST_IDLE;
            default:              state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: operand selection and unit starts.
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        rot_start = 1'b0;
        div_start = 1'b0;
        div_den   = {elapsed_reg, 9'd0};
        unique case (state_reg)
            ddo_pkg::ST_MUL_L:
            begin
                mul_a = ddo_pkg::ROT_W'(signed'(left_cnt_reg - last_left_reg));
                mul_b = ddo_pkg::ROT_W'(left_tick_reg);
            end
            ddo_pkg::ST_MUL_R:
            begin
                mul_a = ddo_pkg::ROT_W'(signed'(right_cnt_reg - last_right_reg));
                mul_b = ddo_pkg::ROT_W'(right_tick_reg);
            end
            ddo_pkg::ST_MUL_H:
            begin
                mul_a = ddo_pkg::ROT_W'(diff_reg);
                mul_b = ddo_pkg::ROT_W'(inv_track_reg);
            end
            ddo_pkg::ST_ROT:
            begin
                rot_start = 1'b1;
            end
            ddo_pkg::ST_MUL_X:
            begin
                mul_a = ddo_pkg::ROT_W'(mean_s);
                mul_b = trig.cos_v;
            end
            ddo_pkg::ST_MUL_Y:
            begin
                mul_a = ddo_pkg::ROT_W'(mean_s);
                mul_b = trig.sin_v;
            end
            ddo_pkg::ST_MUL_F:
            begin
                mul_a = ddo_pkg::ROT_W'(sum_reg);
                mul_b = ddo_pkg::US_PER_S;
            end
            ddo_pkg::ST_MUL_W:
            begin
                mul_a = ddo_pkg::ROT_W'(signed'(h_reg));
                mul_b = ddo_pkg::US_PER_S;
                div_start = 1'b1;
                div_den   = ddo_pkg::DEN_W'(elapsed_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        // The divider starts in the divide state that follows, once its numerator product is registered.
        if (state_reg == ddo_pkg::ST_MUL_W)
        begin
            div_start = 1'b0;
        end
        if ((state_reg == ddo_pkg::ST_DIV_F || state_reg == ddo_pkg::ST_DIV_W) &&
            start_pend_reg)
        begin
            div_start = 1'b1;
            div_den   = (state_reg == ddo_pkg::ST_DIV_F) ? {elapsed_reg, 9'd0}
                                                         : ddo_pkg::DEN_W'(elapsed_reg);
        end
    end

    // The first cycle of each divide state launches the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pend_reg <= 1'b0;
        end
        else
        begin
            start_pend_reg <= (state_reg == ddo_pkg::ST_MUL_F) ||
                              (state_reg == ddo_pkg::ST_MUL_W);
        end
    end

    // State register, configuration and persistent pose.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ddo_pkg::ST_IDLE;
            left_tick_reg  <= ddo_pkg::LEFT_TICK_RST;
            right_tick_reg <= ddo_pkg::RIGHT_TICK_RST;
            inv_track_reg  <= ddo_pkg::INV_TRACK_RST;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            heading_reg    <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    ddo_pkg::REG_LEFT_TICK:  left_tick_reg  <= cfg.data;
                    ddo_pkg::REG_RIGHT_TICK: right_tick_reg <= cfg.data;
                    ddo_pkg::REG_INV_TRACK:  inv_track_reg  <= cfg.data;
                    default:                 left_tick_reg  <= left_tick_reg;
                endcase
            end
            if (state_reg == ddo_pkg::ST_MUL_Y)
            begin
                x_reg <= x_reg + pos_step;
            end
            if (state_reg == ddo_pkg::ST_POS_Y)
            begin
                y_reg          <= y_reg + pos_step;
                heading_reg    <= heading_reg + h_reg;
                last_left_reg  <= left_cnt_reg;
                last_right_reg <= right_cnt_reg;
            end
        end
    end

    // Per-sample datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                left_cnt_reg  <= sample.left_count;
                right_cnt_reg <= sample.right_count;
                elapsed_reg   <= sample.elapsed_us;
            end
            ddo_pkg::ST_MUL_R:
            begin
                left_m_reg <= sat32(prod_reg);
            end
            ddo_pkg::ST_SUM:
            begin
                diff_reg <= 33'(right_m) - 33'(left_m_reg);
                sum_reg  <= 33'(right_m) + 33'(left_m_reg);
            end
            ddo_pkg::ST_HEAD:
            begin
                h_reg <= h_round[55:24];
            end
            ddo_pkg::ST_POS_Y:
            begin
                fault_reg <= (elapsed_reg == 24'd0);
                fwd_reg   <= '0;
                yaw_reg   <= '0;
            end
            ddo_pkg::ST_DIV_F:
            begin
                if (start_pend_reg)
                begin
                    neg_reg <= prod_reg[PROD_W-1];
                end
                if (quot.done)
                begin
                    fwd_reg <= sat_quot(quot.quot, neg_reg);
                end
            end
            ddo_pkg::ST_DIV_W:
            begin
                if (start_pend_reg)
                begin
                    neg_reg <= prod_reg[PROD_W-1];
                end
                if (quot.done)
                begin
                    yaw_reg <= sat_quot(quot.quot, neg_reg);
                end
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    // Rotation unit for the midpoint heading.
    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start),
        .angle (heading_reg + half_h),
        .trig  (trig)
    );

    // Divider shared by forward speed and yaw rate.
    ddo_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (quot)
    );

    // Channel outputs.
    assign sample.ready       = (state_reg == ddo_pkg::ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign pose.valid         = (state_reg == ddo_pkg::ST_OUT);
    assign pose.x_pos         = signed'(x_reg);
    assign pose.y_pos         = signed'(y_reg);
    assign pose.heading_out   = heading_reg[31:16];
    assign pose.forward_speed = fwd_reg;
    assign pose.yaw_rate      = yaw_reg;
    assign pose.time_fault    = fault_reg;

endmodule

>>> rtl/core/ddo_cordic.sv
// Iterative CORDIC rotation giving cosine and sine of a 32-bit turn angle.
module ddo_cordic #(
    parameter int STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         angle,
    output ddo_pkg::ddo_trig_t  trig
);
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                            busy_reg;
    logic                            done_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [1:0]                      quad_reg;
    logic signed [ddo_pkg::ROT_W-1:0] x_reg;
    logic signed [ddo_pkg::ROT_W-1:0] y_reg;
    logic signed [ddo_pkg::ROT_W-1:0] z_reg;

    logic [31:0]                      shifted;
    logic [31:0]                      resid;
    logic [4:0]                       idx;
    logic signed [ddo_pkg::ROT_W-1:0] xs;
    logic signed [ddo_pkg::ROT_W-1:0] ys;
    logic signed [ddo_pkg::ROT_W-1:0] step_angle;

    // Quadrant from the angle advanced by an eighth turn; the rest is rotated.
    assign shifted = angle + 32'h2000_0000;
    assign resid   = angle - {shifted[31:30], 30'd0};

    // One micro-rotation per cycle.
    assign idx        = 5'(cnt_reg);
    assign xs         = x_reg >>> idx;
    assign ys         = y_reg >>> idx;
    assign step_angle = ddo_pkg::ROT_W'(ddo_pkg::atan_turns(idx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Vector and residual angle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quad_reg <= shifted[31:30];
            x_reg    <= ddo_pkg::ROT_X0;
            y_reg    <= '0;
            z_reg    <= ddo_pkg::ROT_W'(signed'(resid));
        end
        else if (busy_reg)
        begin
            if (!z_reg[ddo_pkg::ROT_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_angle;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_angle;
            end
        end
    end

    // Fold the result back into its quadrant.
    always_comb
    begin
        trig.done = done_reg;
        case (quad_reg)
            2'd0:
            begin
                trig.cos_v = x_reg;
                trig.sin_v = y_reg;
            end
            2'd1:
            begin
                trig.cos_v = -y_reg;
                trig.sin_v = x_reg;
            end
            2'd2:
            begin
                trig.cos_v = -x_reg;
                trig.sin_v = -y_reg;
            end
            default:
            begin
                trig.cos_v = y_reg;
                trig.sin_v = -x_reg;
            end
        endcase
    end

endmodule

>>> rtl/core/ddo_divider.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module ddo_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ddo_pkg::NUM_W-1:0]  num,
    input  logic [ddo_pkg::DEN_W-1:0]  den,
    output ddo_pkg::ddo_quot_t         res
);
    localparam int CNT_W = $clog2(ddo_pkg::NUM_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [ddo_pkg::NUM_W-1:0]   num_reg;
    logic [ddo_pkg::DEN_W-1:0]   den_reg;
    logic [ddo_pkg::DEN_W-1:0]   rem_reg;

    logic [ddo_pkg::DEN_W:0]     trial;
    logic                        fits;

    // Bring down the next numerator bit and try the subtraction.
    assign trial = {rem_reg, num_reg[ddo_pkg::NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(ddo_pkg::NUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(ddo_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // The quotient bits shift into the numerator register from the right.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[ddo_pkg::NUM_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= ddo_pkg::DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[ddo_pkg::DEN_W-1:0];
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = num_reg;

endmodule

>>> rtl/core/ddo_checker.sv
// Port-level checks of the odometry block and their binding to the top level.
`include "diff_drive_odometry_macros.svh"

module ddo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        time_fault,
    input logic [31:0] forward_speed,
    input logic [31:0] yaw_rate
);
    // A sample beat makes the block busy in the next cycle.
    `DDO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // No sample is taken while a result waits.
    `DDO_ASSERT_SAME(a_no_accept_while_result, out_valid, !in_ready)
    // A zero time interval gives zero speeds.
    `DDO_ASSERT_SAME(a_fault_zero_speed, out_valid && time_fault, (forward_speed | yaw_rate) == '0)
    // A stalled result stays offered.
    `DDO_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)
endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (pose.valid),
    .out_ready     (pose.ready),
    .time_fault    (pose.time_fault),
    .forward_speed (pose.forward_speed),
    .yaw_rate      (pose.yaw_rate)
);

>>> tb/sv/ddo_pose_checker.sv
// Checker for the odometry block: predicts every pose beat and compares it with the block.
module ddo_pose_checker (
    input  logic  clk,
    input  logic  rst_n,
    ddo_sample_if smp,
    ddo_pose_if   pose,
    ddo_cfg_if    cfg,
    output int    mismatches,
    output int    pending,
    output int    results_seen,
    output int    faults_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [47:0] x_pos;
        logic signed [47:0] y_pos;
        logic        [15:0] heading;
        logic signed [31:0] fwd;
        logic signed [31:0] yaw;
        logic               fault;
    } pose_t;

    // Rotation angles of the CORDIC steps, 2^32 per turn.
    localparam longint ROT_ANGLE [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    // Predicted configuration and pose state.
    logic [31:0] left_tick;
    logic [31:0] right_tick;
    logic [31:0] inv_track;
    logic [31:0] prev_left;
    logic [31:0] prev_right;
    logic [31:0] heading_q;
    logic [47:0] x_q;
    logic [47:0] y_q;
    pose_t       pose_due[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Rate with truncation toward zero, then saturated.
    function automatic logic [31:0] rate_of(input longint num, input longint den);
        longint q;
        q = num / den;
        return 32'(clamp32(q));
    endfunction

    // Dead-reckoning step for one accepted sample beat.
    task automatic advance_pose(input logic [31:0] lc, input logic [31:0] rc,
                                input logic [23:0] el, output pose_t p);
        logic signed [31:0] dl;
        logic signed [31:0] dr;
        longint lm, rm, diff, sum, prod, s, x, y, z, xs, ys, c, sn, dx, dy;
        logic [31:0] h;
        logic [31:0] half;
        logic [31:0] angle;
        logic [1:0]  quad;
        logic [31:0] resid;
        dl = lc - prev_left;
        dr = rc - prev_right;
        lm = clamp32(longint'(dl) * longint'({32'd0, left_tick}));
        rm = clamp32(longint'(dr) * longint'({32'd0, right_tick}));
        diff = rm - lm;
        sum = lm + rm;
        prod = diff * longint'({32'd0, inv_track}) + 64'sh800000;
        h = prod[55:24];
        half = {h[31], h[31:1]};
        s = sum >>> 1;

        // CORDIC rotation of the residual within the chosen quadrant.
        angle = heading_q + half;
        quad = 2'((angle + 32'h2000_0000) >> 30);
        resid = angle - {quad, 30'd0};
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ROT_ANGLE[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ROT_ANGLE[i];
            end
        end
        case (quad)
            2'd0:    begin c = x;  sn = y;  end
            2'd1:    begin c = -y; sn = x;  end
            2'd2:    begin c = -x; sn = -y; end
            default: begin c = y;  sn = -x; end
        endcase
        dx = (s * c + 64'sh2000_0000) >>> 30;
        dy = (s * sn + 64'sh2000_0000) >>> 30;
        x_q = x_q + dx[47:0];
        y_q = y_q + dy[47:0];
        heading_q = heading_q + h;
        prev_left = lc;
        prev_right = rc;

        p.x_pos = x_q;
        p.y_pos = y_q;
        p.heading = heading_q[31:16];
        if (el == 24'd0)
        begin
            p.fwd = '0;
            p.yaw = '0;
            p.fault = 1'b1;
        end
        else
        begin
            p.fwd = rate_of(sum * 1000000, longint'(el) * 512);
            p.yaw = rate_of(longint'($signed(h)) * 1000000, longint'(el));
            p.fault = 1'b0;
        end
    endtask

    // Watch the three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pose_t p;
        pose_t e;
        if (!rst_n)
        begin
            left_tick = ddo_pkg::LEFT_TICK_RST;
            right_tick = ddo_pkg::RIGHT_TICK_RST;
            inv_track = ddo_pkg::INV_TRACK_RST;
            prev_left = '0;
            prev_right = '0;
            heading_q = '0;
            x_q = '0;
            y_q = '0;
            pose_due.delete();
            mismatches = 0;
            results_seen = 0;
            faults_seen = 0;
        end
        else
        begin
            // Register writes; unknown indexes are ignored.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    ddo_pkg::REG_LEFT_TICK:  left_tick = cfg.data;
                    ddo_pkg::REG_RIGHT_TICK: right_tick = cfg.data;
                    ddo_pkg::REG_INV_TRACK:  inv_track = cfg.data;
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
            begin
                advance_pose(smp.left_count, smp.right_count, smp.elapsed_us, p);
                pose_due.push_back(p);
            end
            if (pose.valid && pose.ready)
            begin
                results_seen++;
                if (pose.time_fault)
                    faults_seen++;
                if (pose_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: pose beat with no sample waiting", $realtime);
                end
                else
                begin
                    e = pose_due.pop_front();
                    if (pose.x_pos !== e.x_pos || pose.y_pos !== e.y_pos
                        || pose.heading_out !== e.heading || pose.forward_speed !== e.fwd
                        || pose.yaw_rate !== e.yaw || pose.time_fault !== e.fault)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"%0t: pose mismatch, expected ",
                                      "x=%0d y=%0d hd=%0d v=%0d w=%0d f=%0b"},
                                     $realtime, e.x_pos, e.y_pos, e.heading, e.fwd, e.yaw,
                                     e.fault);
                            $display("      actual   x=%0d y=%0d hd=%0d v=%0d w=%0d f=%0b",
                                     pose.x_pos, pose.y_pos, pose.heading_out,
                                     pose.forward_speed, pose.yaw_rate, pose.time_fault);
                        end
                    end
                end
            end
        end
        pending = pose_due.size();
    end

endmodule

>>> tb/sv/diff_drive_odometry_tb.sv
// Top of the odometry testbench: clock, reset, stimulus, watchdog and verdict.
module diff_drive_odometry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1500;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   results_seen;
    int   faults_seen;
    int   samples_sent;
    int   writes_sent;
    int   stall_cycles;
    bit   steady;
    logic signed [31:0] left_pos;
    logic signed [31:0] right_pos;

    ddo_sample_if sample_ch ();
    ddo_pose_if   pose_ch ();
    ddo_cfg_if    cfg_ch ();

    diff_drive_odometry #(.CORDIC_STEPS(16)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .pose   (pose_ch.source),
        .cfg    (cfg_ch.sink)
    );

    ddo_pose_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .smp          (sample_ch),
        .pose         (pose_ch),
        .cfg          (cfg_ch),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .faults_seen  (faults_seen)
    );

    // Free-running clock.
    initial
        clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on cycles where no channel moves a beat.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (pose_ch.valid && pose_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL diff_drive_odometry");
            $finish;
        end
    end

    // Result side stalls in random bursts, except in the steady tail.
    initial
    begin
        pose_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!steady && $urandom_range(0, 9) == 0)
            begin
                pose_ch.ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            pose_ch.ready = 1'b1;
        end
    end

    // One sample beat, with an optional idle burst before it.
    task automatic send_sample(input logic [31:0] lc, input logic [31:0] rc,
                               input logic [23:0] el);
        bit taken;
        @(negedge clk);
        if (!steady && $urandom_range(0, 7) == 0)
        begin
            sample_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.left_count = lc;
        sample_ch.right_count = rc;
        sample_ch.elapsed_us = el;
        left_pos = lc;
        right_pos = rc;
        taken = 1'b0;
        while (!taken)
        begin
            taken = sample_ch.ready;
            @(posedge clk);
            if (!taken)
                @(negedge clk);
        end
        samples_sent++;
    endtask

    // Register write, issued only once all poses are back and the block is quiet.
    task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        bit taken;
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        taken = 1'b0;
        while (!taken)
        begin
            taken = cfg_ch.ready;
            @(posedge clk);
            if (!taken)
                @(negedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        writes_sent++;
    endtask

    task automatic set_all(input logic [31:0] lt, input logic [31:0] rt,
                           input logic [31:0] it);
        write_reg(ddo_pkg::REG_LEFT_TICK, lt);
        write_reg(ddo_pkg::REG_RIGHT_TICK, rt);
        write_reg(ddo_pkg::REG_INV_TRACK, it);
    endtask

    // Random sample built from the last counts, mostly plausible motion.
    task automatic random_sample();
        int mode;
        logic [31:0] lc;
        logic [31:0] rc;
        logic [23:0] el;
        mode = $urandom_range(0, 99);
        lc = left_pos + ($urandom_range(0, 4000) - 2000);
        rc = right_pos + ($urandom_range(0, 4000) - 2000);
        el = 24'($urandom_range(500, 20000));
        if (mode >= 70 && mode < 80)
        begin
            lc = $urandom;
            rc = $urandom;
            el = 24'($urandom);
        end
        else if (mode >= 80 && mode < 85)
            el = '0;
        else if (mode >= 85 && mode < 93)
        begin
            lc = left_pos + ($urandom_range(0, 2097152) - 1048576);
            rc = right_pos + ($urandom_range(0, 2097152) - 1048576);
            el = 24'($urandom_range(1, 255));
        end
        else if (mode >= 93)
        begin
            lc = left_pos + $urandom_range(0, 1);
            el = 24'($urandom);
        end
        send_sample(lc, rc, el);
    endtask

    initial
    begin
        rst_n = 1'b0;
        steady = 1'b0;
        samples_sent = 0;
        writes_sent = 0;
        stall_cycles = 0;
        left_pos = '0;
        right_pos = '0;
        sample_ch.valid = 1'b0;
        sample_ch.left_count = '0;
        sample_ch.right_count = '0;
        sample_ch.elapsed_us = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: standstill, zero time, full time, counter wrap, saturated travel.
        send_sample(32'd0, 32'd0, 24'd1000);
        send_sample(32'd0, 32'd0, 24'd0);
        send_sample(32'd100, 32'd100, 24'hFFFFFF);
        send_sample(32'd100, 32'd300, 24'd1);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd5000);
        send_sample(32'h8000_0000, 32'h8000_0000, 24'd5000);
        send_sample(32'h8000_0000, 32'h0000_0000, 24'd1);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 24'd0);
        send_sample(32'h0000_0000, 32'hFFFF_0000, 24'd7);
        send_sample(32'h0001_0000, 32'h0000_0000, 24'd1);

        // Register extremes, an unknown index, zero settings, then back to nominal.
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(8'd3, 32'h1234_5678);
        write_reg(8'hFF, 32'hFFFF_FFFF);
        send_sample(32'h0000_0010, 32'h0000_0020, 24'd1);
        send_sample(32'h0000_0000, 32'h0000_0040, 24'd3);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF);
        set_all(32'd0, 32'd0, 32'd0);
        send_sample(32'h1234_5678, 32'h8765_4321, 24'd100);
        send_sample(32'd0, 32'd0, 24'd0);
        set_all(ddo_pkg::LEFT_TICK_RST, ddo_pkg::RIGHT_TICK_RST, ddo_pkg::INV_TRACK_RST);
        send_sample(32'd0, 32'd200000, 24'd10000);
        send_sample(32'd200000, 32'd0, 24'd10000);

        // Random motion, with the settings changed a few times along the way.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 300 == 150 && n < RANDOM_ITEMS - 200)
            begin
                case ($urandom_range(0, 3))
                    0: set_all(ddo_pkg::LEFT_TICK_RST, ddo_pkg::RIGHT_TICK_RST,
                               ddo_pkg::INV_TRACK_RST);
                    1: set_all($urandom, $urandom, $urandom);
                    2: set_all($urandom_range(1, 200000), $urandom_range(1, 200000),
                               $urandom);
                    default: set_all(32'hFFFF_FFFF, $urandom_range(0, 1000), 32'd0);
                endcase
            end
            if (n >= RANDOM_ITEMS - 200)
                steady = 1'b1;
            random_sample();
        end

        // Drain and let the block settle.
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(posedge clk);

        $display("Ran %0d samples and %0d register writes; %0d poses checked, %0d %s",
                 samples_sent, writes_sent, results_seen, faults_seen,
                 "with time fault.");
        $display("Mismatches: %0d, poses still outstanding: %0d.", mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("PASS diff_drive_odometry");
        else
            $display("FAIL diff_drive_odometry");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ddo_pkg.sv
rtl/core/ddo_if.sv
rtl/core/ddo_cordic.sv
rtl/core/ddo_divider.sv
rtl/core/diff_drive_odometry.sv
rtl/core/ddo_checker.sv
tb/sv/ddo_pose_checker.sv
tb/sv/diff_drive_odometry_tb.sv
